[src/dijkstra_shortest_path_assert.svh]
// Assertion macros for the shortest path search block.
// Used by the port checker; expects i_clk and i_rst_n in scope.
`ifndef DIJKSTRA_SHORTEST_PATH_ASSERT_SVH
`define DIJKSTRA_SHORTEST_PATH_ASSERT_SVH

// Consequent checked in the same cycle.
`define DSP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define DSP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/dsp_pkg.sv]
// Shared types and constants of the shortest path search block.
// No dependencies; imported by the controller, datapath, top level and port checker.
`default_nettype none

package dsp_pkg;

    localparam int MAX_NODES_DEF  = 32;
    localparam int MAX_DEGREE_DEF = 16;
    localparam int COST_BITS_DEF  = 8;

    localparam int NODE_BITS    = 5;
    localparam int DIST_BITS    = 13;
    localparam int CMD_BITS     = 2;
    localparam int STAT_BITS    = 2;
    localparam int CFG_BITS     = 6;
    localparam int COST_IN_BITS = 8;
    localparam int RESULT_LIMIT = 32;
    localparam int NODE_CAP     = 32;

    localparam logic [DIST_BITS-1:0] DIST_MAX = '1;
    localparam logic [CFG_BITS-1:0]  NODE_COUNT_RESET = CFG_BITS'(32);

    typedef enum logic [CMD_BITS-1:0] {
        CMD_CLEAR,
        CMD_ADD,
        CMD_SEARCH,
        CMD_NONE
    } t_cmd;

    typedef enum logic [STAT_BITS-1:0] {
        ST_OK,
        ST_FULL,
        ST_RANGE,
        ST_UNREACH
    } t_status;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_CLR_GRAPH,
        OP_LATCH_DEGA,
        OP_WR_A,
        OP_WR_B,
        OP_RESP,
        OP_INIT,
        OP_SETTLE,
        OP_REL_RD,
        OP_REL_UP,
        OP_SCAN,
        OP_PICK,
        OP_UNREACH
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_ADD_DEGA,
        S_ADD_CHK,
        S_ADD_WRA,
        S_ADD_WRB,
        S_RESP,
        S_INIT,
        S_SETTLE,
        S_REL_RD,
        S_REL_UP,
        S_SCAN,
        S_SCAN_END,
        S_UNREACH
    } t_state;

    typedef struct packed {
        t_op     op;
        t_status code;
    } t_dp_cmd;

    typedef struct packed {
        t_cmd cmd;
        logic range_err;
        logic full;
        logic hit;
        logic rel_done;
        logic scan_done;
        logic have;
        logic k_full;
        logic out_free;
    } t_dp_stat;

endpackage

`default_nettype wire

[src/dsp_ctrl.sv]
// Controller state machine of the shortest path search block.
// Depends on dsp_pkg; drives commands to dsp_datapath and reads its status.
`default_nettype none

module dsp_ctrl (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_valid,
    output logic               o_stall,
    input  dsp_pkg::t_dp_stat  i_stat,
    output dsp_pkg::t_dp_cmd   o_cmd
);
    import dsp_pkg::*;

    t_state  r_state;
    t_state  n_state;
    t_status r_code;
    t_status n_code;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_code  <= ST_OK;
        end else begin
            r_state <= n_state;
            r_code  <= n_code;
        end
    end

    always_comb begin
        n_state = r_state;
        n_code  = r_code;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) n_state = S_DECODE;
            end
            S_DECODE: begin
                unique case (i_stat.cmd)
                    CMD_CLEAR: begin
                        n_code  = ST_OK;
                        n_state = S_RESP;
                    end
                    CMD_ADD: begin
                        if (i_stat.range_err) begin
                            n_code  = ST_RANGE;
                            n_state = S_RESP;
                        end else begin
                            n_state = S_ADD_DEGA;
                        end
                    end
                    CMD_SEARCH: begin
                        if (i_stat.range_err) begin
                            n_code  = ST_RANGE;
                            n_state = S_RESP;
                        end else begin
                            n_state = S_INIT;
                        end
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_ADD_DEGA: n_state = S_ADD_CHK;
            S_ADD_CHK: begin
                if (i_stat.full) begin
                    n_code  = ST_FULL;
                    n_state = S_RESP;
                end else begin
                    n_state = S_ADD_WRA;
                end
            end
            S_ADD_WRA: n_state = S_ADD_WRB;
            S_ADD_WRB: begin
                n_code  = ST_OK;
                n_state = S_RESP;
            end
            S_RESP: begin
                if (i_stat.out_free) n_state = S_IDLE;
            end
            S_INIT: n_state = S_SETTLE;
            S_SETTLE: begin
                if (i_stat.out_free) n_state = i_stat.hit ? S_IDLE : S_REL_RD;
            end
            S_REL_RD: n_state = i_stat.rel_done ? S_SCAN : S_REL_UP;
            S_REL_UP: n_state = S_REL_RD;
            S_SCAN: begin
                if (i_stat.scan_done) n_state = S_SCAN_END;
            end
            S_SCAN_END: begin
                n_state = (!i_stat.have || i_stat.k_full) ? S_UNREACH : S_SETTLE;
            end
            S_UNREACH: begin
                if (i_stat.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.op   = OP_NONE;
        o_cmd.code = r_code;
        o_stall    = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) o_cmd.op = OP_LOAD;
            end
            S_DECODE: begin
                if (i_stat.cmd == CMD_CLEAR) o_cmd.op = OP_CLR_GRAPH;
            end
            S_ADD_DEGA: o_cmd.op = OP_LATCH_DEGA;
            S_ADD_WRA:  o_cmd.op = OP_WR_A;
            S_ADD_WRB:  o_cmd.op = OP_WR_B;
            S_RESP: begin
                if (i_stat.out_free) o_cmd.op = OP_RESP;
            end
            S_INIT: o_cmd.op = OP_INIT;
            S_SETTLE: begin
                if (i_stat.out_free) o_cmd.op = OP_SETTLE;
            end
            S_REL_RD: begin
                if (!i_stat.rel_done) o_cmd.op = OP_REL_RD;
            end
            S_REL_UP: o_cmd.op = OP_REL_UP;
            S_SCAN: begin
                if (!i_stat.scan_done) o_cmd.op = OP_SCAN;
            end
            S_SCAN_END: begin
                if (i_stat.have && !i_stat.k_full) o_cmd.op = OP_PICK;
            end
            S_UNREACH: begin
                if (i_stat.out_free) o_cmd.op = OP_UNREACH;
            end
            default: o_cmd.op = OP_NONE;
        endcase
    end

endmodule

`default_nettype wire

[src/dsp_datapath.sv]
// Datapath of the shortest path search block: adjacency memory, degree,
// distance and mark arrays, scan registers and the output register.
// Depends on dsp_pkg; driven by dsp_ctrl.
`default_nettype none

module dsp_datapath #(
    parameter int MAX_NODES  = dsp_pkg::MAX_NODES_DEF,
    parameter int MAX_DEGREE = dsp_pkg::MAX_DEGREE_DEF,
    parameter int COST_BITS  = dsp_pkg::COST_BITS_DEF
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  dsp_pkg::t_dp_cmd                  i_cmd,
    output dsp_pkg::t_dp_stat                 o_stat,
    input  wire  [dsp_pkg::CMD_BITS-1:0]      i_cmd_in,
    input  wire  [dsp_pkg::NODE_BITS-1:0]     i_node_a,
    input  wire  [dsp_pkg::NODE_BITS-1:0]     i_node_b,
    input  wire  [dsp_pkg::COST_IN_BITS-1:0]  i_cost,
    input  wire                               i_cfg_valid,
    input  wire  [dsp_pkg::CFG_BITS-1:0]      i_cfg_data,
    input  wire                               i_stall,
    output logic                              o_valid,
    output logic [dsp_pkg::NODE_BITS-1:0]     o_node,
    output logic [dsp_pkg::NODE_BITS-1:0]     o_parent,
    output logic [dsp_pkg::DIST_BITS-1:0]     o_distance,
    output logic                              o_found,
    output logic [dsp_pkg::STAT_BITS-1:0]     o_status,
    output logic                              o_last
);
    import dsp_pkg::*;

    localparam int NODE_LIMIT = (MAX_NODES < NODE_CAP) ? MAX_NODES : NODE_CAP;
    localparam int NW    = $clog2(NODE_LIMIT);
    localparam int DGW   = $clog2(MAX_DEGREE + 1);
    localparam int DEPTH = NODE_LIMIT * MAX_DEGREE;
    localparam int AW    = $clog2(DEPTH);
    localparam int CB    = (COST_BITS < COST_IN_BITS) ? COST_BITS : COST_IN_BITS;
    localparam int MW    = NODE_BITS + CB;

    function automatic logic [AW-1:0] f_addr(input logic [NW-1:0] nd,
                                             input logic [DGW-1:0] sl);
        return AW'(nd) * AW'(MAX_DEGREE) + AW'(sl);
    endfunction

    logic [MW-1:0]           r_mem [DEPTH];
    logic [MW-1:0]           r_rd;
    logic [DGW-1:0]          r_degree [NODE_LIMIT];
    logic [DIST_BITS-1:0]    r_dist [NODE_LIMIT];
    logic [NODE_BITS-1:0]    r_pred [NODE_LIMIT];
    logic [NODE_LIMIT-1:0]   r_reached;
    logic [NODE_LIMIT-1:0]   r_settled;
    logic [CFG_BITS-1:0]     r_node_count;

    t_cmd                    r_cmd;
    logic [NODE_BITS-1:0]    r_a;
    logic [NODE_BITS-1:0]    r_b;
    logic [CB-1:0]           r_w;
    logic [DGW-1:0]          r_deg_a;
    logic [NODE_BITS-1:0]    r_cur;
    logic [DIST_BITS-1:0]    r_dist_cur;
    logic [DGW-1:0]          r_deg_cur;
    logic [DGW-1:0]          r_idx;
    logic [CFG_BITS-1:0]     r_scan;
    logic [NODE_BITS-1:0]    r_best;
    logic [DIST_BITS-1:0]    r_best_d;
    logic                    r_have;
    logic [CFG_BITS-1:0]     r_k;
    logic                    r_out_valid;

    logic [CFG_BITS-1:0]     n_eff;
    logic [NW-1:0]           a_idx;
    logic [NW-1:0]           b_idx;
    logic [NW-1:0]           cur_idx;
    logic [NW-1:0]           deg_addr;
    logic [DGW-1:0]          deg_rd;
    logic [AW-1:0]           mem_addr;
    logic                    mem_we;
    logic [MW-1:0]           mem_wdata;
    logic [NODE_BITS-1:0]    rel_nb;
    logic [CB-1:0]           rel_w;
    logic [NW-1:0]           nb_idx;
    logic [DIST_BITS:0]      rel_sum;
    logic [DIST_BITS-1:0]    rel_nd;
    logic                    rel_take;
    logic [NW-1:0]           sc_idx;
    logic                    sc_take;
    logic                    out_free;
    logic                    out_load;
    logic                    hit;
    logic                    full;

    assign a_idx   = r_a[NW-1:0];
    assign b_idx   = r_b[NW-1:0];
    assign cur_idx = r_cur[NW-1:0];

    always_comb begin
        if (r_node_count == '0) begin
            n_eff = CFG_BITS'(1);
        end else if (r_node_count > CFG_BITS'(NODE_LIMIT)) begin
            n_eff = CFG_BITS'(NODE_LIMIT);
        end else begin
            n_eff = r_node_count;
        end
    end

    always_comb begin
        case (i_cmd.op)
            OP_LATCH_DEGA, OP_WR_A: deg_addr = a_idx;
            OP_SETTLE:              deg_addr = cur_idx;
            default:                deg_addr = b_idx;
        endcase
    end
    assign deg_rd = r_degree[deg_addr];

    always_comb begin
        if (r_a == r_b) begin
            full = ({1'b0, r_deg_a} + (DGW+1)'(2)) > (DGW+1)'(MAX_DEGREE);
        end else begin
            full = (r_deg_a >= DGW'(MAX_DEGREE)) || (deg_rd >= DGW'(MAX_DEGREE));
        end
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_wdata = {r_b, r_w};
        mem_addr  = f_addr(cur_idx, r_idx);
        case (i_cmd.op)
            OP_WR_A: begin
                mem_we    = 1'b1;
                mem_wdata = {r_b, r_w};
                mem_addr  = f_addr(a_idx, r_deg_a);
            end
            OP_WR_B: begin
                mem_we    = 1'b1;
                mem_wdata = {r_a, r_w};
                mem_addr  = f_addr(b_idx, deg_rd);
            end
            default: mem_we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_addr] <= mem_wdata;
        r_rd <= r_mem[mem_addr];
    end

    assign rel_nb   = r_rd[MW-1:CB];
    assign rel_w    = r_rd[CB-1:0];
    assign nb_idx   = rel_nb[NW-1:0];
    assign rel_sum  = (DIST_BITS+1)'(r_dist_cur) + (DIST_BITS+1)'(rel_w);
    assign rel_nd   = rel_sum[DIST_BITS] ? DIST_MAX : rel_sum[DIST_BITS-1:0];
    assign rel_take = ({1'b0, rel_nb} < n_eff) && !r_settled[nb_idx]
                      && (!r_reached[nb_idx] || (rel_nd < r_dist[nb_idx]));

    assign sc_idx  = r_scan[NW-1:0];
    assign sc_take = r_reached[sc_idx] && !r_settled[sc_idx]
                     && (!r_have || (r_dist[sc_idx] < r_best_d));

    assign out_free = !r_out_valid || !i_stall;
    assign out_load = (i_cmd.op == OP_SETTLE) || (i_cmd.op == OP_RESP)
                      || (i_cmd.op == OP_UNREACH);
    assign hit      = (r_cur == r_b);

    assign o_stat.cmd       = r_cmd;
    assign o_stat.range_err = ({1'b0, r_a} >= n_eff) || ({1'b0, r_b} >= n_eff);
    assign o_stat.full      = full;
    assign o_stat.hit       = hit;
    assign o_stat.rel_done  = (r_idx == r_deg_cur);
    assign o_stat.scan_done = (r_scan == n_eff);
    assign o_stat.have      = r_have;
    assign o_stat.k_full    = (r_k >= CFG_BITS'(RESULT_LIMIT));
    assign o_stat.out_free  = out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NODE_LIMIT; i++) r_degree[i] <= '0;
            r_reached    <= '0;
            r_settled    <= '0;
            r_node_count <= NODE_COUNT_RESET;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) r_node_count <= i_cfg_data;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            case (i_cmd.op)
                OP_CLR_GRAPH: begin
                    for (int i = 0; i < NODE_LIMIT; i++) r_degree[i] <= '0;
                end
                OP_WR_A: r_degree[a_idx] <= r_deg_a + DGW'(1);
                OP_WR_B: r_degree[b_idx] <= deg_rd + DGW'(1);
                OP_INIT: begin
                    r_reached <= NODE_LIMIT'(1) << a_idx;
                    r_settled <= '0;
                end
                OP_SETTLE: r_settled[cur_idx] <= 1'b1;
                OP_REL_UP: begin
                    if (rel_take) r_reached[nb_idx] <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_cmd <= t_cmd'(i_cmd_in);
                r_a   <= i_node_a;
                r_b   <= i_node_b;
                r_w   <= i_cost[CB-1:0];
            end
            OP_LATCH_DEGA: r_deg_a <= deg_rd;
            OP_RESP: begin
                o_node     <= '0;
                o_parent   <= '0;
                o_distance <= '0;
                o_found    <= 1'b0;
                o_status   <= i_cmd.code;
                o_last     <= 1'b1;
            end
            OP_INIT: begin
                r_dist[a_idx] <= '0;
                r_pred[a_idx] <= r_a;
                r_cur         <= r_a;
                r_k           <= '0;
            end
            OP_SETTLE: begin
                o_node     <= r_cur;
                o_parent   <= r_pred[cur_idx];
                o_distance <= r_dist[cur_idx];
                o_found    <= hit;
                o_status   <= ST_OK;
                o_last     <= hit;
                r_dist_cur <= r_dist[cur_idx];
                r_deg_cur  <= deg_rd;
                r_idx      <= '0;
                r_scan     <= '0;
                r_have     <= 1'b0;
                r_k        <= r_k + CFG_BITS'(1);
            end
            OP_REL_UP: begin
                if (rel_take) begin
                    r_dist[nb_idx] <= rel_nd;
                    r_pred[nb_idx] <= r_cur;
                end
                r_idx <= r_idx + DGW'(1);
            end
            OP_SCAN: begin
                if (sc_take) begin
                    r_best   <= NODE_BITS'(r_scan);
                    r_best_d <= r_dist[sc_idx];
                    r_have   <= 1'b1;
                end
                r_scan <= r_scan + CFG_BITS'(1);
            end
            OP_PICK: r_cur <= r_best;
            OP_UNREACH: begin
                o_node     <= r_b;
                o_parent   <= '0;
                o_distance <= '0;
                o_found    <= 1'b0;
                o_status   <= ST_UNREACH;
                o_last     <= 1'b1;
            end
            default: ;
        endcase
    end

    assign o_valid = r_out_valid;

endmodule

`default_nettype wire

[src/dijkstra_shortest_path.sv]
// Top level of the shortest path search block over a small weighted graph.
// Depends on dsp_pkg, dsp_ctrl and dsp_datapath.
//
// Usage:
//   Input channel (i_valid / o_stall) takes one command item: clear the graph,
//   add an undirected edge, or search from node_a to node_b. o_stall is low
//   only while the block is idle; one item is worked on at a time.
//   Output channel (o_valid / i_stall) returns result items from one output
//   register; each command's final item carries o_last.
//   Configuration channel (i_cfg_valid / o_cfg_ready) writes node_count, is
//   always ready and must only be used while the block is idle (not enforced).
// Steps: add and search first check both nodes against node_count. Clear
//   clears the graph and responds; add latches node_a's degree, checks for a
//   full list, writes both entries and responds; cmd 3 gives no result. A
//   search initialises, then per settled node emits it, relaxes each adjacency
//   entry (registered memory read, then relax), then the linear minimum scan.
// Reset (synchronous, active low) empties the graph and sets node_count to 32.
// A stalled output holds its item and the block waits before the next result.
`default_nettype none

module dijkstra_shortest_path #(
    parameter int MAX_NODES  = dsp_pkg::MAX_NODES_DEF,
    parameter int MAX_DEGREE = dsp_pkg::MAX_DEGREE_DEF,
    parameter int COST_BITS  = dsp_pkg::COST_BITS_DEF
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_valid,
    output logic                              o_stall,
    input  wire  [dsp_pkg::CMD_BITS-1:0]      i_cmd,
    input  wire  [dsp_pkg::NODE_BITS-1:0]     i_node_a,
    input  wire  [dsp_pkg::NODE_BITS-1:0]     i_node_b,
    input  wire  [dsp_pkg::COST_IN_BITS-1:0]  i_cost,
    input  wire                               i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire  [dsp_pkg::CFG_BITS-1:0]      i_cfg_data,
    output logic                              o_valid,
    input  wire                               i_stall,
    output logic [dsp_pkg::NODE_BITS-1:0]     o_node,
    output logic [dsp_pkg::NODE_BITS-1:0]     o_parent,
    output logic [dsp_pkg::DIST_BITS-1:0]     o_distance,
    output logic                              o_found,
    output logic [dsp_pkg::STAT_BITS-1:0]     o_status,
    output logic                              o_last
);
    import dsp_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    assign o_cfg_ready = 1'b1;

    dsp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd)
    );

    dsp_datapath #(
        .MAX_NODES  (MAX_NODES),
        .MAX_DEGREE (MAX_DEGREE),
        .COST_BITS  (COST_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .o_stat      (dp_stat),
        .i_cmd_in    (i_cmd),
        .i_node_a    (i_node_a),
        .i_node_b    (i_node_b),
        .i_cost      (i_cost),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_stall     (i_stall),
        .o_valid     (o_valid),
        .o_node      (o_node),
        .o_parent    (o_parent),
        .o_distance  (o_distance),
        .o_found     (o_found),
        .o_status    (o_status),
        .o_last      (o_last)
    );

endmodule

`default_nettype wire

[src/dsp_checker.sv]
// Port checker for the shortest path search block, bound to the top level.
// Depends on dijkstra_shortest_path_assert.svh and dsp_pkg.
`default_nettype none

`include "dijkstra_shortest_path_assert.svh"

module dsp_checker (
    input wire                            i_clk,
    input wire                            i_rst_n,
    input wire                            i_valid,
    input wire                            o_stall,
    input wire                            o_valid,
    input wire                            i_stall,
    input wire [dsp_pkg::NODE_BITS-1:0]   o_node,
    input wire                            o_found,
    input wire [dsp_pkg::STAT_BITS-1:0]   o_status,
    input wire                            o_last
);
    import dsp_pkg::*;

    `DSP_ASSERT_NEXT(a_busy_after_accept, i_valid && !o_stall, o_stall, "accepted item did not block the input")
    `DSP_ASSERT_NOW(a_found_is_last, o_valid && o_found, o_last, "target result not marked last")
    `DSP_ASSERT_NOW(a_unreach_is_last, o_valid && (o_status == ST_UNREACH), o_last && !o_found, "unreachable result malformed")
    `DSP_ASSERT_NEXT(a_hold_on_stall, o_valid && i_stall, o_valid && $stable(o_node) && $stable(o_last), "stalled item changed")

endmodule

bind dijkstra_shortest_path dsp_checker u_dsp_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_valid  (i_valid),
    .o_stall  (o_stall),
    .o_valid  (o_valid),
    .i_stall  (i_stall),
    .o_node   (o_node),
    .o_found  (o_found),
    .o_status (o_status),
    .o_last   (o_last)
);

`default_nettype wire
